@@ design/dew_point_comfort_class_macros.svh @@
// Assertion macros for the dew point and comfort class block
`ifndef DEW_POINT_COMFORT_CLASS_MACROS_SVH
`define DEW_POINT_COMFORT_CLASS_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define DPC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds once the delay dly has passed after ante
`define DPC_ASSERT_DLY(label, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

@@ design/dpc_pkg.sv @@
// Shared types, widths and constants for the dew point and comfort class block
package dpc_pkg;

    localparam int TEMP_W   = 14;
    localparam int HUM_W    = 14;
    localparam int DP_W     = 15;
    localparam int CLASS_W  = 4;
    localparam int LOG_FRAC = 24;
    localparam int LOG_W    = 28;
    localparam int MANT_W   = 31;
    localparam int N_CLASS  = 8;

    localparam logic signed [DP_W-1:0] DP_MIN = -15'sd9000;
    localparam logic signed [DP_W-1:0] DP_MAX = 15'sd8000;

    localparam logic signed [DP_W-1:0] CLASS_LIMIT [N_CLASS] = '{
        15'sd2600, 15'sd2400, 15'sd2100, 15'sd1800,
        15'sd1600, 15'sd1300, 15'sd1000, 15'sd500
    };

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic [HUM_W-1:0]         humidity;
    } dpc_in_t;

    typedef struct packed {
        logic signed [DP_W-1:0] dewpt;
        logic [CLASS_W-1:0]     comfort_class;
        logic                   invalid;
    } dpc_out_t;

    // log2 in Q.24 by repeated squaring, for constants
    function automatic logic [LOG_W-1:0] log2_q24(input logic [31:0] x);
        logic [4:0]          e;
        logic [63:0]         m;
        logic [LOG_FRAC-1:0] frac;
        e    = '0;
        frac = '0;
        for (int i = 1; i < 32; i++) begin
            if ((x >> i) != 32'd0) begin
                e = 5'(i);
            end
        end
        m = 64'(x) << (30 - e);
        for (int i = 1; i <= LOG_FRAC; i++) begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                frac[LOG_FRAC-i] = 1'b1;
            end
        end
        return {e[LOG_W-LOG_FRAC-1:0], frac};
    endfunction

endpackage

@@ design/dew_point_comfort_class.sv @@
// Top level: dew point by the Arden Buck form and comfort class, fully pipelined
// One request is taken every cycle (busy stays low) and each gives one result,
// marked by done; the receiver cannot stall, so results leave in request order
// with no gaps of their own. The pipeline is made of the curve-term divider
// (25 stages), the log2 squaring pipeline (25 stages), the final divider
// (16 stages) and twelve stages of input capture, multiply, round and saturate.
// Zero humidity raises invalid and gives a dew point and class of zero.
`include "dew_point_comfort_class_macros.svh"

module dew_point_comfort_class (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  dpc_pkg::dpc_in_t  sample,
    output logic              done,
    output dpc_pkg::dpc_out_t result
);

    import dpc_pkg::*;

    localparam int A_W    = 29;
    localparam int CT_W   = 16;
    localparam int P_W    = 43;
    localparam int FDEN_W = 40;
    localparam int FA_W   = 63;
    localparam int FQ_W   = 25;
    localparam int F_W    = 26;
    localparam int D_W    = 29;
    localparam int LP_W   = 59;
    localparam int LN_W   = 26;
    localparam int G_W    = 27;
    localparam int N2_W   = 51;
    localparam int DEN2_W = 37;
    localparam int A2_W   = 50;
    localparam int DQ_W   = 16;
    localparam int LATENCY = 4 + FQ_W + 1 + (LOG_FRAC + 1) + 6 + DQ_W + 1;

    localparam logic [A_W-1:0]           K_A    = 29'd437999100;
    localparam logic [24:0]              K_FDEN = 25'd23450000;
    localparam logic [29:0]              K_LN2  = 30'd744261118;
    localparam logic [24:0]              K_N2   = 25'd25714000;
    localparam logic signed [DEN2_W-1:0] K_B    = DEN2_W'(64'd18678 << 20);
    localparam logic [LOG_W-1:0]         L_FULL = log2_q24(32'd10000);

    // stage 0: input request
    logic                     v0_reg;
    logic signed [TEMP_W-1:0] t0_reg;
    logic [HUM_W-1:0]         h0_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        t0_reg <= sample.temperature;
        h0_reg <= sample.humidity;
    end

    // stage 1: factors of the curve term
    logic                     v1_reg;
    logic [A_W-1:0]           a1_reg;
    logic [A_W-1:0]           a1_next;
    logic [CT_W-1:0]          ct1_reg;
    logic [CT_W-1:0]          ct1_next;
    logic signed [TEMP_W-1:0] t1_reg;
    logic [HUM_W-1:0]         h1_reg;
    logic signed [24:0]       t1000;
    logic signed [A_W:0]      a1_wide;
    logic signed [CT_W:0]     ct1_wide;

    always_comb
    begin
        t1000    = 25'(t0_reg) * 25'sd1000;
        a1_wide  = $signed({1'b0, K_A}) - (A_W+1)'(t1000);
        a1_next  = a1_wide[A_W-1:0];
        ct1_wide = 17'sd25714 + (CT_W+1)'(t0_reg);
        ct1_next = ct1_wide[CT_W-1:0];
    end

    // stage 2: products
    logic                     v2_reg;
    logic signed [P_W-1:0]    p2_reg;
    logic signed [P_W-1:0]    p2_next;
    logic [FDEN_W-1:0]        fden2_reg;
    logic [FDEN_W-1:0]        fden2_next;
    logic [HUM_W-1:0]         h2_reg;

    always_comb
    begin
        p2_next    = P_W'($signed({1'b0, a1_reg})) * P_W'(t1_reg);
        fden2_next = FDEN_W'(K_FDEN) * FDEN_W'(ct1_reg);
    end

    // stage 3: rounded dividend magnitude
    logic                     v3_reg;
    logic [FA_W-1:0]          fa3_reg;
    logic [FA_W-1:0]          fa3_next;
    logic [FDEN_W-1:0]        fden3_reg;
    logic                     fneg3_reg;
    logic [HUM_W-1:0]         h3_reg;
    logic [P_W-1:0]           pmag;

    always_comb
    begin
        pmag     = p2_reg[P_W-1] ? P_W'(-p2_reg) : P_W'(p2_reg);
        fa3_next = (FA_W'(pmag) << 20) + FA_W'(fden2_reg >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a1_reg    <= a1_next;
        ct1_reg   <= ct1_next;
        t1_reg    <= t0_reg;
        h1_reg    <= h0_reg;
        p2_reg    <= p2_next;
        fden2_reg <= fden2_next;
        h2_reg    <= h1_reg;
        fa3_reg   <= fa3_next;
        fden3_reg <= fden2_reg;
        fneg3_reg <= p2_reg[P_W-1];
        h3_reg    <= h2_reg;
    end

    // curve term divider
    logic              vf;
    logic [FQ_W-1:0]   qf;
    logic [HUM_W:0]    sf;

    dpc_div #(
        .NUM_W  (FA_W),
        .DEN_W  (FDEN_W),
        .Q_W    (FQ_W),
        .SIDE_W (HUM_W + 1)
    ) u_div_curve (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .num       (fa3_reg),
        .den       (fden3_reg),
        .side_in   ({fneg3_reg, h3_reg}),
        .out_valid (vf),
        .quo       (qf),
        .side_out  (sf)
    );

    // stage 4: signed curve term
    logic                  v4_reg;
    logic signed [F_W-1:0] f4_reg;
    logic signed [F_W-1:0] f4_next;
    logic                  z4_reg;
    logic [HUM_W-1:0]      h4_reg;

    assign f4_next = sf[HUM_W] ? -$signed(F_W'(qf)) : $signed(F_W'(qf));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= vf;
        end
    end

    always_ff @(posedge clk)
    begin
        f4_reg <= f4_next;
        z4_reg <= (sf[HUM_W-1:0] == '0);
        h4_reg <= sf[HUM_W-1:0];
    end

    // log2 of humidity
    logic             vl;
    logic [LOG_W-1:0] lq;
    logic [F_W:0]     sl;

    dpc_log2 #(
        .SIDE_W (F_W + 1)
    ) u_log2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .x         (h4_reg),
        .side_in   ({z4_reg, f4_reg}),
        .out_valid (vl),
        .log_val   (lq),
        .side_out  (sl)
    );

    // stages 5 to 10: ln, gamma, final dividend and divisor
    logic                     v5_reg, v6_reg, v7_reg, v8_reg, v9_reg, v10_reg;
    logic                     z5_reg, z6_reg, z7_reg, z8_reg, z9_reg;
    logic signed [F_W-1:0]    f5_reg, f6_reg, f7_reg;
    logic signed [D_W-1:0]    d5_reg;
    logic signed [LP_W-1:0]   lp6_reg;
    logic signed [LP_W-1:0]   lp6_next;
    logic signed [LN_W-1:0]   ln7_reg;
    logic signed [LN_W-1:0]   ln7_next;
    logic [LP_W-1:0]          lmag;
    logic [LP_W-1:0]          lrnd;
    logic signed [G_W-1:0]    g8_reg;
    logic signed [N2_W-1:0]   n9_reg;
    logic signed [N2_W-1:0]   n9_next;
    logic signed [DEN2_W-1:0] den9_reg;
    logic signed [DEN2_W-1:0] den9_next;
    logic [A2_W-1:0]          a10_reg;
    logic [A2_W-1:0]          a10_next;
    logic [DEN2_W-2:0]        den10_reg;
    logic                     neg10_reg;
    logic                     bad10_reg;
    logic [N2_W-1:0]          nmag;
    logic                     den9_ok;

    always_comb
    begin
        lp6_next  = LP_W'(d5_reg) * LP_W'($signed({1'b0, K_LN2}));
        lmag      = lp6_reg[LP_W-1] ? LP_W'(-lp6_reg) : LP_W'(lp6_reg);
        lrnd      = (lmag + (LP_W'(1) << 33)) >> 34;
        ln7_next  = lp6_reg[LP_W-1] ? -$signed(lrnd[LN_W-1:0]) : $signed(lrnd[LN_W-1:0]);
        n9_next   = N2_W'(g8_reg) * N2_W'($signed({1'b0, K_N2}));
        den9_next = K_B - DEN2_W'(g8_reg) * 37'sd1000;
        nmag      = n9_reg[N2_W-1] ? N2_W'(-n9_reg) : N2_W'(n9_reg);
        den9_ok   = !den9_reg[DEN2_W-1] && (den9_reg != '0);
        a10_next  = A2_W'(nmag) + A2_W'(den9_reg[DEN2_W-2:1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end
        else
        begin
            v5_reg  <= vl;
            v6_reg  <= v5_reg;
            v7_reg  <= v6_reg;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d5_reg    <= $signed({1'b0, lq}) - $signed({1'b0, L_FULL});
        f5_reg    <= sl[F_W-1:0];
        z5_reg    <= sl[F_W];
        lp6_reg   <= lp6_next;
        f6_reg    <= f5_reg;
        z6_reg    <= z5_reg;
        ln7_reg   <= ln7_next;
        f7_reg    <= f6_reg;
        z7_reg    <= z6_reg;
        g8_reg    <= G_W'(ln7_reg) + G_W'(f7_reg);
        z8_reg    <= z7_reg;
        n9_reg    <= n9_next;
        den9_reg  <= den9_next;
        z9_reg    <= z8_reg;
        a10_reg   <= a10_next;
        den10_reg <= den9_reg[DEN2_W-2:0];
        neg10_reg <= n9_reg[N2_W-1];
        bad10_reg <= z9_reg || !den9_ok;
    end

    // dew point divider
    logic            vd;
    logic [DQ_W-1:0] qd;
    logic [1:0]      sd;

    dpc_div #(
        .NUM_W  (A2_W),
        .DEN_W  (DEN2_W - 1),
        .Q_W    (DQ_W),
        .SIDE_W (2)
    ) u_div_dew (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v10_reg),
        .num       (a10_reg),
        .den       (den10_reg),
        .side_in   ({neg10_reg, bad10_reg}),
        .out_valid (vd),
        .quo       (qd),
        .side_out  (sd)
    );

    // output stage: sign, saturate, classify
    logic                   done_reg;
    dpc_out_t               result_reg;
    dpc_out_t               result_next;
    logic signed [DQ_W+1:0] sv;
    logic signed [DP_W-1:0] dp_sat;
    logic [CLASS_W-1:0]     cls;

    always_comb
    begin
        sv = sd[1] ? -$signed({2'b00, qd}) : $signed({2'b00, qd});
        if (sv < DP_MIN)
        begin
            dp_sat = DP_MIN;
        end
        else if (sv > DP_MAX)
        begin
            dp_sat = DP_MAX;
        end
        else
        begin
            dp_sat = sv[DP_W-1:0];
        end
        cls = '0;
        for (int i = N_CLASS - 1; i >= 0; i--) begin
            if (dp_sat > CLASS_LIMIT[i])
            begin
                cls = CLASS_W'(N_CLASS - i);
            end
        end
        result_next.invalid = sd[0];
        if (sd[0])
        begin
            result_next.dewpt         = '0;
            result_next.comfort_class = '0;
        end
        else
        begin
            result_next.dewpt         = dp_sat;
            result_next.comfort_class = cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vd;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `DPC_ASSERT_DLY(a_latency, start && !busy, LATENCY, done, "result missing after request")
    `DPC_ASSERT_IMP(a_dp_range, done && !result.invalid, ($signed(result.dewpt) >= DP_MIN) && ($signed(result.dewpt) <= DP_MAX), "dew point outside saturation range")
    `DPC_ASSERT_IMP(a_invalid_zero, done && result.invalid, (result.dewpt == '0) && (result.comfort_class == '0), "invalid result carries non-zero fields")
    `DPC_ASSERT_IMP(a_class_top, done && !result.invalid && ($signed(result.dewpt) > CLASS_LIMIT[0]), result.comfort_class == CLASS_W'(N_CLASS), "top comfort class missed")

endmodule

@@ design/dpc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage
module dpc_div #(
    parameter int NUM_W  = 63,
    parameter int DEN_W  = 40,
    parameter int Q_W    = 25,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [Q_W-1:0]    quo,
    output logic [SIDE_W-1:0] side_out
);

    localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [CW-1:0]     rem_reg   [Q_W];
    logic [DEN_W-1:0]  den_reg   [Q_W];
    logic [Q_W-1:0]    q_reg     [Q_W];
    logic [SIDE_W-1:0] side_reg  [Q_W];
    logic              valid_reg [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [CW-1:0]     rem_in;
        logic [CW-1:0]     trial;
        logic [CW-1:0]     rem_next;
        logic [DEN_W-1:0]  den_in;
        logic [Q_W-1:0]    q_in;
        logic [Q_W-1:0]    q_next;
        logic [SIDE_W-1:0] side_k;
        logic              valid_in;

        if (k == 0) begin : g_first
            assign rem_in   = CW'(num);
            assign den_in   = den;
            assign q_in     = '0;
            assign side_k   = side_in;
            assign valid_in = in_valid;
        end
        else begin : g_next
            assign rem_in   = rem_reg[k-1];
            assign den_in   = den_reg[k-1];
            assign q_in     = q_reg[k-1];
            assign side_k   = side_reg[k-1];
            assign valid_in = valid_reg[k-1];
        end

        assign trial = CW'(den_in) << (Q_W - 1 - k);

        always_comb
        begin
            rem_next = rem_in;
            q_next   = q_in;
            if (rem_in >= trial)
            begin
                rem_next = rem_in - trial;
                q_next[Q_W-1-k] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            den_reg[k]  <= den_in;
            q_reg[k]    <= q_next;
            side_reg[k] <= side_k;
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign quo       = q_reg[Q_W-1];
    assign side_out  = side_reg[Q_W-1];

endmodule

@@ design/dpc_log2.sv @@
// Pipelined log2 in Q.24: normalise, then one squaring per fraction bit
module dpc_log2 #(
    parameter int SIDE_W = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [dpc_pkg::HUM_W-1:0]   x,
    input  logic [SIDE_W-1:0]           side_in,
    output logic                        out_valid,
    output logic [dpc_pkg::LOG_W-1:0]   log_val,
    output logic [SIDE_W-1:0]           side_out
);

    import dpc_pkg::*;

    localparam int EXP_W = LOG_W - LOG_FRAC;

    logic [MANT_W-1:0] m_reg     [LOG_FRAC+1];
    logic [LOG_W-1:0]  acc_reg   [LOG_FRAC+1];
    logic [SIDE_W-1:0] side_reg  [LOG_FRAC+1];
    logic              valid_reg [LOG_FRAC+1];

    logic [EXP_W-1:0]  e0;
    logic [MANT_W-1:0] m0;

    always_comb
    begin
        e0 = '0;
        m0 = MANT_W'(x) << (MANT_W - 1);
        for (int i = 1; i < HUM_W; i++) begin
            if (x[i])
            begin
                e0 = EXP_W'(i);
                m0 = MANT_W'(x) << (MANT_W - 1 - i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg[0]    <= m0;
        acc_reg[0]  <= {e0, {LOG_FRAC{1'b0}}};
        side_reg[0] <= side_in;
    end

    for (genvar k = 1; k <= LOG_FRAC; k++) begin : g_sq
        logic [2*MANT_W-1:0] sq;
        logic [MANT_W:0]     s;
        logic [MANT_W-1:0]   m_next;
        logic [LOG_W-1:0]    acc_next;

        assign sq = (2*MANT_W)'(m_reg[k-1]) * (2*MANT_W)'(m_reg[k-1]);
        assign s  = sq[2*MANT_W-1:MANT_W-1];

        always_comb
        begin
            acc_next = acc_reg[k-1];
            if (s[MANT_W])
            begin
                m_next = s[MANT_W:1];
                acc_next[LOG_FRAC-k] = 1'b1;
            end
            else
            begin
                m_next = s[MANT_W-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            m_reg[k]    <= m_next;
            acc_reg[k]  <= acc_next;
            side_reg[k] <= side_reg[k-1];
        end
    end

    assign out_valid = valid_reg[LOG_FRAC];
    assign log_val   = acc_reg[LOG_FRAC];
    assign side_out  = side_reg[LOG_FRAC];

endmodule
